### sv/sparse_table_range_minimum_macros.svh
// ---------------------------------------------------------------------------
// Sparse table range minimum - assertion macros
// Concurrent assertion wrappers shared by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef SPARSE_TABLE_RANGE_MINIMUM_MACROS_SVH
`define SPARSE_TABLE_RANGE_MINIMUM_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define SRMQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define SRMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SRMQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SRMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/srmq_pkg.sv
// ---------------------------------------------------------------------------
// Sparse table range minimum - package
// Sizes, request and status codes, and small helper functions.
// ---------------------------------------------------------------------------
package srmq_pkg;

  // Table geometry
  localparam int DEPTH     = 1024;
  localparam int LEVELS    = 10;
  localparam int POS_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JCNT_W    = $clog2(LEVELS + 1);
  localparam int SZ_W      = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
  localparam int ADDR_W    = LVL_W + POS_W;
  localparam int MEM_WORDS = LEVELS << POS_W;

  // Item fields
  localparam int DATA_W = 64;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = IDX_W + 1;
  localparam int LOG_W  = $clog2(LEN_W);
  localparam int CMP_W  = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  // Signed minimum of two values
  function automatic logic signed [DATA_W-1:0] smin(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    return (a <= b) ? a : b;
  endfunction

  // Position of the highest set bit; zero for zero
  function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] x);
    logic [LOG_W-1:0] res;
    res = '0;
    for (int i = 1; i < LEN_W; i++) begin
      if (x[i]) res = LOG_W'(i);
    end
    return res;
  endfunction

endpackage

### sv/sparse_table_range_minimum.sv
// ---------------------------------------------------------------------------
// Sparse table range minimum
// Range-minimum engine over a sparse table of signed 64-bit values, built
// one value per append, held in one synchronous single-read memory.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_* and raise start; the transfer happens at a clock edge
//   with start high and busy low. busy stays high until the result is out.
//   Result: out_valid pulses for one cycle with out_min_value and out_status.
//   Append: writes level 0 at the transfer, then reads one level-(j-1) entry
//   per cycle and writes level j in the following cycle. The result transfers
//   after the level walk ends; the chain of per-level minimums through the
//   single read port means a new append is taken only once busy drops.
//   Query: two or three reads of one level, one per cycle; the result
//   transfers after the last read is folded. Clear, unused codes, full table
//   and bad range go straight to the result. busy drops after every result.
//   Reset empties the table (count to zero); no clearing pass runs, as every
//   entry read was written since the last clear.
//   The receiver cannot stall: each result is taken in its strobe cycle.
// ---------------------------------------------------------------------------
`include "sparse_table_range_minimum_macros.svh"

module sparse_table_range_minimum (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_req_type,
  input  logic signed [srmq_pkg::DATA_W-1:0]     in_value,
  input  logic [srmq_pkg::IDX_W-1:0]             in_left_index,
  input  logic [srmq_pkg::IDX_W-1:0]             in_right_index,
  output logic                                   out_valid,
  output logic signed [srmq_pkg::DATA_W-1:0]     out_min_value,
  output logic [1:0]                             out_status
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_APPEND = 4'b0010,
    ST_QUERY  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [srmq_pkg::CNT_W-1:0]            count_r, count_nxt;
  logic [srmq_pkg::POS_W-1:0]            p_r, p_nxt;
  logic [srmq_pkg::JCNT_W-1:0]           j_r, j_nxt;
  logic signed [srmq_pkg::DATA_W-1:0]    cur_r, cur_nxt;
  logic signed [srmq_pkg::DATA_W-1:0]    acc_r, acc_nxt;
  srmq_pkg::status_t                     status_r, status_nxt;
  logic                                  pend_r, pend_nxt;
  logic [srmq_pkg::LVL_W-1:0]            pend_lvl_r, pend_lvl_nxt;
  logic [srmq_pkg::POS_W-1:0]            pend_pos_r, pend_pos_nxt;
  logic                                  first_r, first_nxt;
  logic [srmq_pkg::LVL_W-1:0]            qlvl_r, qlvl_nxt;
  logic [srmq_pkg::SZ_W-1:0]             qsize_r, qsize_nxt;
  logic [srmq_pkg::SZ_W-1:0]             s_r, s_nxt;
  logic [srmq_pkg::SZ_W-1:0]             end_r, end_nxt;

  // Memory ports
  logic                                  rd_en;
  logic [srmq_pkg::ADDR_W-1:0]           rd_addr;
  logic signed [srmq_pkg::DATA_W-1:0]    rd_data_r;
  logic                                  wr_en;
  logic [srmq_pkg::ADDR_W-1:0]           wr_addr;
  logic signed [srmq_pkg::DATA_W-1:0]    wr_data;

  logic signed [srmq_pkg::DATA_W-1:0]    level_table_mem [srmq_pkg::MEM_WORDS];

  // Decode helpers
  logic                                  accept;
  logic                                  table_full;
  logic                                  q_bad;
  logic [srmq_pkg::LEN_W-1:0]            q_len;
  logic [srmq_pkg::LOG_W-1:0]            q_log;
  logic [srmq_pkg::LVL_W-1:0]            q_lvl;
  logic [srmq_pkg::SZ_W-1:0]             size_j;
  logic [srmq_pkg::SZ_W-1:0]             p_plus1;
  logic [srmq_pkg::SZ_W-1:0]             app_start;
  logic                                  app_issue;
  logic signed [srmq_pkg::DATA_W-1:0]    app_min;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = (state_r == ST_DONE);
  assign out_min_value = acc_r;
  assign out_status    = status_r;

  // Query range checks and block level
  assign table_full = (count_r >= srmq_pkg::CNT_W'(srmq_pkg::DEPTH));
  assign q_bad = (in_left_index > in_right_index) ||
                 (srmq_pkg::CMP_W'(in_right_index) >= srmq_pkg::CMP_W'(count_r));
  assign q_len = srmq_pkg::LEN_W'(in_right_index) - srmq_pkg::LEN_W'(in_left_index) +
                 srmq_pkg::LEN_W'(1);
  assign q_log = srmq_pkg::floor_log2(q_len);
  assign q_lvl = (int'(q_log) > srmq_pkg::LEVELS - 1) ?
                 srmq_pkg::LVL_W'(srmq_pkg::LEVELS - 1) : srmq_pkg::LVL_W'(q_log);

  // Append level walk: block of 2^j ending at the new position
  assign size_j    = srmq_pkg::SZ_W'(1) << j_r;
  assign p_plus1   = srmq_pkg::SZ_W'(p_r) + srmq_pkg::SZ_W'(1);
  assign app_start = p_plus1 - size_j;
  assign app_issue = (j_r < srmq_pkg::JCNT_W'(srmq_pkg::LEVELS)) && (p_plus1 >= size_j);
  assign app_min   = srmq_pkg::smin(cur_r, rd_data_r);

  // Next-state and memory control
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    p_nxt        = p_r;
    j_nxt        = j_r;
    cur_nxt      = cur_r;
    acc_nxt      = acc_r;
    status_nxt   = status_r;
    pend_nxt     = pend_r;
    pend_lvl_nxt = pend_lvl_r;
    pend_pos_nxt = pend_pos_r;
    first_nxt    = first_r;
    qlvl_nxt     = qlvl_r;
    qsize_nxt    = qsize_r;
    s_nxt        = s_r;
    end_nxt      = end_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = in_value;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt    = '0;
          status_nxt = srmq_pkg::STAT_OK;
          pend_nxt   = 1'b0;
          state_nxt  = ST_DONE;
          case (in_req_type)
            srmq_pkg::REQ_APPEND: begin
              if (table_full) begin
                status_nxt = srmq_pkg::STAT_FULL;
              end else begin
                // Store level 0 now, walk upper levels next
                wr_en     = 1'b1;
                wr_addr   = {srmq_pkg::LVL_W'(0), count_r[srmq_pkg::POS_W-1:0]};
                wr_data   = in_value;
                p_nxt     = count_r[srmq_pkg::POS_W-1:0];
                j_nxt     = srmq_pkg::JCNT_W'(1);
                cur_nxt   = in_value;
                count_nxt = count_r + srmq_pkg::CNT_W'(1);
                state_nxt = ST_APPEND;
              end
            end
            srmq_pkg::REQ_QUERY: begin
              if (q_bad) begin
                status_nxt = srmq_pkg::STAT_BAD_RANGE;
              end else begin
                acc_nxt   = srmq_pkg::DATA_MAX;
                first_nxt = 1'b1;
                qlvl_nxt  = q_lvl;
                qsize_nxt = srmq_pkg::SZ_W'(1) << q_lvl;
                s_nxt     = srmq_pkg::SZ_W'(in_left_index);
                end_nxt   = srmq_pkg::SZ_W'(in_right_index) + srmq_pkg::SZ_W'(1);
                state_nxt = ST_QUERY;
              end
            end
            srmq_pkg::REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_APPEND: begin
        // Retire the previous level: min of read entry and running block
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = {pend_lvl_r, pend_pos_r};
          wr_data = app_min;
          cur_nxt = app_min;
        end
        // Issue the read for the next level, or finish
        if (app_issue) begin
          rd_en        = 1'b1;
          rd_addr      = {srmq_pkg::LVL_W'(j_r - srmq_pkg::JCNT_W'(1)),
                          app_start[srmq_pkg::POS_W-1:0]};
          pend_nxt     = 1'b1;
          pend_lvl_nxt = srmq_pkg::LVL_W'(j_r);
          pend_pos_nxt = app_start[srmq_pkg::POS_W-1:0];
          j_nxt        = j_r + srmq_pkg::JCNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_QUERY: begin
        // Fold the block read last cycle
        if (pend_r) begin
          acc_nxt = srmq_pkg::smin(acc_r, rd_data_r);
        end
        if (first_r) begin
          // Block ending at the right edge
          rd_en     = 1'b1;
          rd_addr   = {qlvl_r, srmq_pkg::POS_W'(end_r - qsize_r)};
          first_nxt = 1'b0;
          pend_nxt  = 1'b1;
        end else if ((s_r + qsize_r) <= end_r) begin
          // Consecutive blocks from the left edge
          rd_en    = 1'b1;
          rd_addr  = {qlvl_r, s_r[srmq_pkg::POS_W-1:0]};
          s_nxt    = s_r + qsize_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    j_r        <= j_nxt;
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    status_r   <= status_nxt;
    pend_lvl_r <= pend_lvl_nxt;
    pend_pos_r <= pend_pos_nxt;
    first_r    <= first_nxt;
    qlvl_r     <= qlvl_nxt;
    qsize_r    <= qsize_nxt;
    s_r        <= s_nxt;
    end_r      <= end_nxt;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      level_table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= level_table_mem[rd_addr];
    end
  end

  // Checks
  `SRMQ_ASSERT_IMPLY(a_no_rw_collide, clk, rst_n, wr_en && rd_en, wr_addr != rd_addr)
  `SRMQ_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid && !busy)
  `SRMQ_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= srmq_pkg::CNT_W'(srmq_pkg::DEPTH))
  `SRMQ_ASSERT_NEXT(a_bad_query_fast, clk, rst_n, accept && (in_req_type == srmq_pkg::REQ_QUERY) && q_bad, out_valid && (out_status == srmq_pkg::STAT_BAD_RANGE))

endmodule
